@@ rtl/core/cbm_pkg.sv @@
// Shared types and constants for the cartridge bank mapper.
package cbm_pkg;

   typedef enum logic [1:0] {
      CMD_WRITE     = 2'd0,
      CMD_TICK      = 2'd1,
      CMD_CPU_XLATE = 2'd2,
      CMD_PPU_XLATE = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      TGT_NONE = 2'd0,
      TGT_PRG  = 2'd1,
      TGT_RAM  = 2'd2,
      TGT_CHR  = 2'd3
   } target_type;

   localparam int unsigned OFFSET_W  = 21;
   localparam int unsigned REQ_DATA_W = 40;
   localparam int unsigned RSP_DATA_W = 24;

   typedef logic [3:0][7:0] prg_bank_array_type;
   typedef logic [7:0][7:0] chr_bank_array_type;

   typedef struct packed {
      logic [OFFSET_W-1:0] rom_offset;
      target_type          target;
   } xlate_result_type;

   localparam logic [15:0] ADDR_MIRROR_A = 16'h42FE;
   localparam logic [15:0] ADDR_MIRROR_B = 16'h42FF;
   localparam logic [15:0] ADDR_IRQ_OFF  = 16'h4501;
   localparam logic [15:0] ADDR_CNT_LO   = 16'h4502;
   localparam logic [15:0] ADDR_CNT_HI   = 16'h4503;
   localparam logic [15:0] ADDR_PRG_LO   = 16'h4504;
   localparam logic [15:0] ADDR_PRG_HI   = 16'h4507;
   localparam logic [15:0] ADDR_CHR_LO   = 16'h4510;
   localparam logic [15:0] ADDR_CHR_HI   = 16'h4517;

   localparam logic [15:0] ADDR_FIXED_BANK = 16'hE000;
   localparam logic [15:0] ADDR_PRG_WIN    = 16'h8000;
   localparam logic [15:0] ADDR_RAM_WIN    = 16'h6000;
   localparam logic [15:0] ADDR_PPU_TOP    = 16'h2000;

   localparam logic [16:0] TICK_STEP    = 17'd114;
   localparam logic [8:0]  LAST_IRQ_LINE = 9'd240;

   localparam logic [7:0]  LAST_PRG_RESET = 8'd255;
   localparam logic [1:0]  MIRROR_RESET   = 2'd2;

endpackage

@@ rtl/core/cbm_translate.sv @@
// CPU and PPU address translation to ROM or RAM byte offsets.
module cbm_translate (
   input  cbm_pkg::command_type        command,
   input  logic [15:0]                 address,
   input  logic [7:0]                  last_prg_bank,
   input  cbm_pkg::prg_bank_array_type prg_banks,
   input  cbm_pkg::chr_bank_array_type chr_banks,
   output cbm_pkg::xlate_result_type   result
);
   import cbm_pkg::*;

   always_comb begin
      result.rom_offset = '0;
      result.target     = TGT_NONE;
      case (command)
         CMD_CPU_XLATE: begin
            if (address >= ADDR_FIXED_BANK) begin
               result.rom_offset = {last_prg_bank, address[12:0]};
               result.target     = TGT_PRG;
            end else if (address >= ADDR_PRG_WIN) begin
               result.rom_offset = {prg_banks[address[14:13]], address[12:0]};
               result.target     = TGT_PRG;
            end else if (address >= ADDR_RAM_WIN) begin
               result.rom_offset = {8'd0, address[12:0]};
               result.target     = TGT_RAM;
            end
         end
         CMD_PPU_XLATE: begin
            if (address < ADDR_PPU_TOP) begin
               result.rom_offset = {3'd0, chr_banks[address[12:10]], address[9:0]};
               result.target     = TGT_CHR;
            end
         end
         default: begin
            result.rom_offset = '0;
            result.target     = TGT_NONE;
         end
      endcase
   end

endmodule

@@ rtl/core/cartridge_bank_mapper_scanline_irq_unit.sv @@
// Top level of the cartridge bank mapper with scanline IRQ counter.
//
//  channel | direction | tdata / wdata                               | tuser
//  req     | in        | address, value, scanline, rendering_on     | command
//  rsp     | out       | rom_offset, irq, mirroring                  | target
//  csr     | in        | last_prg_bank                               | -
//
// One word per cycle while rsp does not stall; each word waits in the input
// register, then its result is registered for rsp as the state updates.
// Synchronous reset restores bank, mirroring and counter registers.
// A stalled rsp holds its word; req stays open while the result register drains.
module cartridge_bank_mapper_scanline_irq_unit (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [15:0] address, [23:16] value, [32:24] scanline, [33] rendering_on
   input  logic [cbm_pkg::REQ_DATA_W-1:0] req_tdata,
   // [1:0] command
   input  logic [1:0]                     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [20:0] rom_offset, [21] irq, [23:22] mirroring
   output logic [cbm_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [1:0] target
   output logic [1:0]                     rsp_tuser,
   input  logic                           csr_we,
   input  logic [7:0]                     csr_wdata
);
   import cbm_pkg::*;

   logic               in_valid_ff, in_valid_in;
   command_type        cmd_ff;
   logic [15:0]        addr_ff;
   logic [7:0]         value_ff;
   logic [8:0]         line_ff;
   logic               render_ff;

   logic [7:0]         last_prg_ff;
   prg_bank_array_type prg_ff, prg_in;
   chr_bank_array_type chr_ff, chr_in;
   logic [1:0]         mirror_ff, mirror_in;
   logic               irq_en_ff, irq_en_in;
   logic [15:0]        count_ff, count_in;

   logic                  out_valid_ff, out_valid_in;
   logic [OFFSET_W-1:0]   out_offset_ff;
   target_type            out_target_ff;
   logic                  out_irq_ff;
   logic [1:0]            out_mirror_ff;

   logic             fire;
   logic             irq_fire;
   logic [16:0]      tick_sum;
   xlate_result_type xlate;

   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   cbm_translate u_translate (
      .command       (cmd_ff),
      .address       (addr_ff),
      .last_prg_bank (last_prg_ff),
      .prg_banks     (prg_ff),
      .chr_banks     (chr_ff),
      .result        (xlate)
   );

   assign tick_sum = {1'b0, count_ff} + TICK_STEP;

   always_comb begin
      prg_in    = prg_ff;
      chr_in    = chr_ff;
      mirror_in = mirror_ff;
      irq_en_in = irq_en_ff;
      count_in  = count_ff;
      irq_fire  = 1'b0;
      if (fire) begin
         case (cmd_ff)
            CMD_WRITE: begin
               case (addr_ff) inside
                  ADDR_MIRROR_A, ADDR_MIRROR_B: mirror_in = {addr_ff[0], value_ff[4]};
                  ADDR_IRQ_OFF: irq_en_in = 1'b0;
                  ADDR_CNT_LO:  count_in  = {count_ff[15:8], value_ff};
                  ADDR_CNT_HI: begin
                     count_in  = {value_ff, count_ff[7:0]};
                     irq_en_in = 1'b1;
                  end
                  [ADDR_PRG_LO:ADDR_PRG_HI]: prg_in[addr_ff[1:0]] = value_ff;
                  [ADDR_CHR_LO:ADDR_CHR_HI]: chr_in[addr_ff[2:0]] = value_ff;
                  default: ;
               endcase
            end
            CMD_TICK: begin
               if (line_ff <= LAST_IRQ_LINE && render_ff && irq_en_ff) begin
                  if (tick_sum[16]) begin
                     irq_fire  = 1'b1;
                     irq_en_in = 1'b0;
                     count_in  = '0;
                  end else begin
                     count_in = tick_sum[15:0];
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign in_valid_in  = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = fire || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         last_prg_ff  <= LAST_PRG_RESET;
         prg_ff       <= {8'd3, 8'd2, 8'd1, 8'd0};
         chr_ff       <= {8'd7, 8'd6, 8'd5, 8'd4, 8'd3, 8'd2, 8'd1, 8'd0};
         mirror_ff    <= MIRROR_RESET;
         irq_en_ff    <= 1'b0;
         count_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         prg_ff       <= prg_in;
         chr_ff       <= chr_in;
         mirror_ff    <= mirror_in;
         irq_en_ff    <= irq_en_in;
         count_ff     <= count_in;
         if (csr_we) begin
            last_prg_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         cmd_ff    <= command_type'(req_tuser);
         addr_ff   <= req_tdata[15:0];
         value_ff  <= req_tdata[23:16];
         line_ff   <= req_tdata[32:24];
         render_ff <= req_tdata[33];
      end
      if (fire) begin
         out_offset_ff <= xlate.rom_offset;
         out_target_ff <= xlate.target;
         out_irq_ff    <= irq_fire;
         out_mirror_ff <= mirror_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_mirror_ff, out_irq_ff, out_offset_ff};
   assign rsp_tuser  = out_target_ff;

   // irq only ever comes from a tick, which never translates
   a_irq_no_target: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_irq_ff |-> out_target_ff == TGT_NONE)
      else $error("irq reported alongside a translation");

   a_irq_disables: assert property (@(posedge clock) disable iff (reset)
      irq_fire |=> !irq_en_ff && count_ff == 16'd0)
      else $error("counter overflow did not clear and disable");

   a_ram_window: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && out_target_ff == TGT_RAM |-> out_offset_ff[OFFSET_W-1:13] == '0)
      else $error("RAM offset outside 8K window");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff)
      else $error("input word lost while result register stalled");

endmodule

@@ dv/tb_cartridge_bank_mapper_scanline_irq_unit.sv @@
// Testbench for the cartridge bank mapper: directed and random stream traffic checked against a scoreboard.
import cbm_pkg::*;

class mapper_scoreboard;
   typedef struct {
      logic [OFFSET_W-1:0] offset;
      target_type          target;
      bit                  irq;
      logic [1:0]          mirror;
   } mapper_result_type;

   mapper_result_type due[$];
   logic [7:0]     last_bank;
   logic [7:0]     prg[4];
   logic [7:0]     chr[8];
   logic [1:0]     mirror;
   bit             irq_en;
   logic [15:0]    count;
   int             errors;

   function new();
      last_bank = LAST_PRG_RESET;
      for (int i = 0; i < 4; i++) prg[i] = 8'(i);
      for (int i = 0; i < 8; i++) chr[i] = 8'(i);
      mirror = MIRROR_RESET;
      irq_en = 0;
      count  = '0;
      errors = 0;
   endfunction

   function void set_last_bank(logic [7:0] v);
      last_bank = v;
   endfunction

   function int pending();
      return due.size();
   endfunction

   function void note_request(command_type cmd, logic [15:0] addr, logic [7:0] val,
                              logic [8:0] scan, bit render);
      mapper_result_type r;
      logic [16:0]    sum;
      r.offset = '0;
      r.target = TGT_NONE;
      r.irq    = 0;
      case (cmd)
         CMD_WRITE: begin
            if (addr == ADDR_MIRROR_A || addr == ADDR_MIRROR_B) begin
               mirror = {addr[0], val[4]};
            end else if (addr == ADDR_IRQ_OFF) begin
               irq_en = 0;
            end else if (addr == ADDR_CNT_LO) begin
               count[7:0] = val;
            end else if (addr == ADDR_CNT_HI) begin
               count[15:8] = val;
               irq_en = 1;
            end else if (addr >= ADDR_PRG_LO && addr <= ADDR_PRG_HI) begin
               prg[addr[1:0]] = val;
            end else if (addr >= ADDR_CHR_LO && addr <= ADDR_CHR_HI) begin
               chr[addr[2:0]] = val;
            end
         end
         CMD_TICK: begin
            if (scan <= LAST_IRQ_LINE && render && irq_en) begin
               sum = {1'b0, count} + TICK_STEP;
               if (sum[16]) begin
                  irq_en = 0;
                  count  = '0;
                  r.irq  = 1;
               end else begin
                  count = sum[15:0];
               end
            end
         end
         CMD_CPU_XLATE: begin
            if (addr >= ADDR_FIXED_BANK) begin
               r.offset = {last_bank, addr[12:0]};
               r.target = TGT_PRG;
            end else if (addr >= ADDR_PRG_WIN) begin
               r.offset = {prg[addr[14:13]], addr[12:0]};
               r.target = TGT_PRG;
            end else if (addr >= ADDR_RAM_WIN) begin
               r.offset = {8'd0, addr[12:0]};
               r.target = TGT_RAM;
            end
         end
         default: begin
            if (addr < ADDR_PPU_TOP) begin
               r.offset = {3'd0, chr[addr[12:10]], addr[9:0]};
               r.target = TGT_CHR;
            end
         end
      endcase
      r.mirror = mirror;
      due.push_back(r);
   endfunction

   function void check_response(logic [RSP_DATA_W-1:0] data, logic [1:0] user);
      mapper_result_type r;
      if (due.size() == 0) begin
         $error("unexpected rsp word: tdata %0h tuser %0h", data, user);
         errors++;
         return;
      end
      r = due.pop_front();
      if (data[20:0] !== r.offset) begin
         $error("rom_offset: expected %0h, actual %0h", r.offset, data[20:0]);
         errors++;
      end
      if (user !== r.target) begin
         $error("target: expected %0d, actual %0d", r.target, user);
         errors++;
      end
      if (data[21] !== r.irq) begin
         $error("irq: expected %0d, actual %0d", r.irq, data[21]);
         errors++;
      end
      if (data[23:22] !== r.mirror) begin
         $error("mirroring: expected %0d, actual %0d", r.mirror, data[23:22]);
         errors++;
      end
   endfunction
endclass

module tb_cartridge_bank_mapper_scanline_irq_unit;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PHASES       = 6;
   localparam int PHASE_WORDS  = 265;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  csr_we;
   logic [7:0]            csr_wdata;

   mapper_scoreboard sb;
   bit               no_idle;
   int               cycle_count;

   cartridge_bank_mapper_scanline_irq_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_cartridge_bank_mapper_scanline_irq_unit: done, errors");
         $finish;
      end
   end

   task automatic send_word(command_type cmd, logic [15:0] addr, logic [7:0] val,
                            logic [8:0] scan, bit render);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tuser  <= cmd;
      req_tdata  <= {6'd0, render, scan, val, addr};
      do @(posedge clock); while (!req_tready);
      sb.note_request(cmd, addr, val, scan, render);
      @(negedge clock);
   endtask

   // sender stops until the scoreboard is empty, then lets the pipe settle
   task automatic drain();
      req_tvalid <= 0;
      while (sb.pending() > 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_last_bank(logic [7:0] v);
      drain();
      csr_we    <= 1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 0;
      sb.set_last_bank(v);
   endtask

   task automatic send_random();
      command_type cmd;
      logic [15:0] addr;
      logic [7:0]  val;
      logic [8:0]  scan;
      bit          render;
      int          pick;
      addr   = 16'($urandom_range(0, 16'hFFFF));
      val    = 8'($urandom_range(0, 255));
      scan   = 9'($urandom_range(0, 261));
      render = 1'($urandom_range(0, 1));
      pick   = $urandom_range(0, 99);
      if (pick < 30) begin
         cmd = CMD_WRITE;
         case ($urandom_range(0, 5))
            0: addr = 16'(ADDR_MIRROR_A + $urandom_range(0, 1));
            1: addr = ADDR_IRQ_OFF;
            2: addr = ADDR_CNT_LO;
            3: begin
               addr = ADDR_CNT_HI;
               if ($urandom_range(0, 1)) val = 8'($urandom_range(8'hF0, 8'hFF));
            end
            4: addr = 16'(ADDR_PRG_LO + $urandom_range(0, 3));
            default: addr = 16'(ADDR_CHR_LO + $urandom_range(0, 7));
         endcase
      end else if (pick < 35) begin
         cmd = CMD_WRITE;
         if ($urandom_range(0, 1)) addr = 16'(16'h4500 + $urandom_range(0, 16'h1F));
      end else if (pick < 60) begin
         cmd = CMD_TICK;
         if ($urandom_range(0, 4) != 0) scan = 9'($urandom_range(0, LAST_IRQ_LINE));
         if ($urandom_range(0, 9) != 0) render = 1;
      end else if (pick < 80) begin
         cmd = CMD_CPU_XLATE;
      end else begin
         cmd = CMD_PPU_XLATE;
         if ($urandom_range(0, 3) != 0) addr = 16'($urandom_range(0, 16'h1FFF));
      end
      send_word(cmd, addr, val, scan, render);
   endtask

   initial begin
      int rsp_gap;
      rsp_tready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         rsp_gap = no_idle ? 0 : $urandom_range(0, 17);
         if (rsp_gap > 0) begin
            rsp_tready <= 0;
            repeat (rsp_gap) @(negedge clock);
         end
         rsp_tready <= 1;
         do @(posedge clock); while (!rsp_tvalid);
         sb.check_response(rsp_tdata, rsp_tuser);
         @(negedge clock);
      end
   end

   initial begin
      logic [7:0] bank_plan[PHASES];
      sb          = new();
      cycle_count = 0;
      no_idle     = 0;
      reset       = 1;
      req_tvalid  = 0;
      req_tdata   = '0;
      req_tuser   = CMD_WRITE;
      csr_we      = 0;
      csr_wdata   = '0;
      bank_plan[0] = 8'd0;
      bank_plan[1] = 8'd255;
      bank_plan[2] = 8'($urandom_range(0, 255));
      bank_plan[3] = 8'd1;
      bank_plan[4] = 8'($urandom_range(0, 255));
      bank_plan[5] = 8'd128;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      @(negedge clock);

      // mirroring, bank writes and an undecoded address
      send_word(CMD_WRITE, ADDR_MIRROR_A, 8'h10, 9'd0, 1'b0);
      send_word(CMD_WRITE, ADDR_MIRROR_B, 8'h10, 9'd0, 1'b0);
      send_word(CMD_WRITE, ADDR_MIRROR_B, 8'hEF, 9'd0, 1'b0);
      send_word(CMD_WRITE, 16'h4500, 8'hFF, 9'd0, 1'b0);
      send_word(CMD_WRITE, ADDR_PRG_LO, 8'hFF, 9'd0, 1'b0);
      send_word(CMD_WRITE, ADDR_PRG_HI, 8'h80, 9'd0, 1'b0);
      send_word(CMD_WRITE, ADDR_CHR_HI, 8'hFF, 9'd0, 1'b0);
      // translation windows at their edges
      send_word(CMD_CPU_XLATE, 16'h5FFF, 8'h00, 9'd0, 1'b0);
      send_word(CMD_CPU_XLATE, 16'h6000, 8'h00, 9'd0, 1'b0);
      send_word(CMD_CPU_XLATE, 16'h7FFF, 8'h00, 9'd0, 1'b0);
      send_word(CMD_CPU_XLATE, 16'h8000, 8'h00, 9'd0, 1'b0);
      send_word(CMD_CPU_XLATE, 16'hC000, 8'h00, 9'd0, 1'b0);
      send_word(CMD_CPU_XLATE, 16'hDFFF, 8'h00, 9'd0, 1'b0);
      send_word(CMD_CPU_XLATE, 16'hE000, 8'h00, 9'd0, 1'b0);
      send_word(CMD_CPU_XLATE, 16'hFFFF, 8'hFF, 9'd261, 1'b1);
      send_word(CMD_PPU_XLATE, 16'h1FFF, 8'h00, 9'd0, 1'b0);
      send_word(CMD_PPU_XLATE, 16'h2000, 8'h00, 9'd0, 1'b0);
      // counter: disabled tick, gated ticks, overflow, self-disable, explicit disable
      send_word(CMD_TICK, 16'h0000, 8'h00, 9'd0, 1'b1);
      send_word(CMD_WRITE, ADDR_CNT_LO, 8'h8C, 9'd0, 1'b0);
      send_word(CMD_WRITE, ADDR_CNT_HI, 8'hFF, 9'd0, 1'b0);
      send_word(CMD_TICK, 16'h0000, 8'h00, 9'd241, 1'b1);
      send_word(CMD_TICK, 16'h0000, 8'h00, 9'd10, 1'b0);
      send_word(CMD_TICK, 16'h0000, 8'h00, 9'd240, 1'b1);
      send_word(CMD_TICK, 16'h0000, 8'h00, 9'd0, 1'b1);
      send_word(CMD_TICK, 16'h0000, 8'h00, 9'd0, 1'b1);
      send_word(CMD_WRITE, ADDR_CNT_HI, 8'hFF, 9'd0, 1'b0);
      send_word(CMD_WRITE, ADDR_IRQ_OFF, 8'h00, 9'd0, 1'b0);
      send_word(CMD_TICK, 16'h0000, 8'h00, 9'd5, 1'b1);

      for (int p = 0; p < PHASES; p++) begin
         write_last_bank(bank_plan[p]);
         send_word(CMD_CPU_XLATE, 16'(16'hE000 + $urandom_range(0, 16'h1FFF)), 8'h00,
                   9'd0, 1'b0);
         for (int n = 0; n < PHASE_WORDS; n++) begin
            if (n % 64 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 199) == 0) drain();
            send_random();
         end
      end

      no_idle = 0;
      drain();
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb_cartridge_bank_mapper_scanline_irq_unit: done, clean");
      end else begin
         $display("tb_cartridge_bank_mapper_scanline_irq_unit: done, errors");
      end
      $finish;
   end
endmodule

@@ cartridge_bank_mapper_scanline_irq_unit.f @@
rtl/core/cbm_pkg.sv
rtl/core/cbm_translate.sv
rtl/core/cartridge_bank_mapper_scanline_irq_unit.sv
dv/tb_cartridge_bank_mapper_scanline_irq_unit.sv
